/* rtl/scp_pkg.sv */
package scp_pkg;

	// field widths of the transaction payloads
	localparam int COORD_W   = 32;
	localparam int QUAT_W    = 16;
	localparam int RAD_W     = 31;
	localparam int REG_IDX_W = 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SPHERE_RADIUS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CYLINDER_RADIUS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CYLINDER_LENGTH = 2'd2;

	localparam logic [RAD_W-1:0] SPHERE_RADIUS_RST   = 31'd65536;
	localparam logic [RAD_W-1:0] CYLINDER_RADIUS_RST = 31'd65536;
	localparam logic [RAD_W-1:0] CYLINDER_LENGTH_RST = 31'd131072;

	// internal datapath widths
	localparam int QP_W     = 2 * QUAT_W;
	localparam int RC_W     = QP_W + 2;
	localparam int DV_W     = COORD_W + 1;
	localparam int PF_W     = RC_W + DV_W;
	localparam int WIDE_W   = 76;
	localparam int RND_SH   = 28;
	localparam int RND_W    = WIDE_W - RND_SH;
	localparam int LOC_W    = 39;
	localparam int MAG_W    = LOC_W - 1;
	localparam int SM_W     = 31;
	localparam int SH_W     = 3;
	localparam int SQ_W     = 2 * SM_W;
	localparam int SUM_W    = 64;
	localparam int ROOT_W   = SUM_W / 2;
	localparam int DEN_W    = ROOT_W + 8;
	localparam int RLO_W    = 19;
	localparam int RHI_W    = MAG_W - RLO_W;
	localparam int PP_W     = RLO_W + RAD_W;
	localparam int NUM_W    = MAG_W + RAD_W;
	localparam int QUO_W    = 33;
	localparam int LANES    = 6;
	localparam int PT_W     = LOC_W + 2;
	localparam int SPLIT_LO = 20;
	localparam int PH_W     = PT_W - SPLIT_LO;
	localparam int MP_W     = RC_W + PH_W;

	localparam logic signed [RC_W-1:0] ONE_Q28 = 34'sd268435456;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [QUAT_W-1:0]  quat_t;
	typedef logic signed [RC_W-1:0]    coef_t;
	typedef logic signed [LOC_W-1:0]   loc_t;
	typedef coef_t [2:0][2:0]          rmat_t;

	typedef struct packed {
		coord_t sphere_x;
		coord_t sphere_y;
		coord_t sphere_z;
		coord_t cyl_x;
		coord_t cyl_y;
		coord_t cyl_z;
		quat_t  quat_w;
		quat_t  quat_i;
		quat_t  quat_j;
		quat_t  quat_k;
		logic   swap_order;
	} query_t;

	typedef struct packed {
		coord_t distance;
		coord_t first_x;
		coord_t first_y;
		coord_t first_z;
		coord_t second_x;
		coord_t second_y;
		coord_t second_z;
		logic   degenerate;
	} result_t;

	// geometry that rides along the root and quotient pipelines
	typedef struct packed {
		loc_t [2:0]   l;
		loc_t         a2;
		logic [2:0]   neg;
		coord_t [2:0] t;
		rmat_t        r;
		logic         swap;
	} geo_t;

	typedef struct packed {
		logic [SH_W-1:0]             sh;
		logic [LANES-1:0][NUM_W-1:0] num;
		geo_t                        geo;
	} sq_side_t;

	typedef struct packed {
		geo_t   geo;
		logic   deg;
		coord_t sep;
	} div_side_t;

	localparam logic signed [RND_W-1:0] CMAX_EXT =
		{{(RND_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [RND_W-1:0] CMIN_EXT =
		{{(RND_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	// product in q28 scaled down, rounded half away from zero
	function automatic logic signed [RND_W-1:0] rnd28(input logic signed [WIDE_W-1:0] p);
		logic signed [WIDE_W-1:0] b;
		logic signed [WIDE_W-1:0] s;
		if (p[WIDE_W-1]) begin
			b = {{(WIDE_W-RND_SH+1){1'b0}}, {(RND_SH-1){1'b1}}};
		end else begin
			b = {{(WIDE_W-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};
		end
		s = p + b;
		return s[WIDE_W-1:RND_SH];
	endfunction

	// clamp to the signed coordinate range
	function automatic coord_t sat_coord(input logic signed [RND_W-1:0] v);
		coord_t r;
		if (v > CMAX_EXT) begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v < CMIN_EXT) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/sphere_capsule_proximity_core.sv */
// Sphere to capsule proximity: each query transaction carries a sphere centre, a cylinder
// pose (Q16.16 position, Q2.14 quaternion) and an order flag, and yields one result with the
// signed distance, the two nearest points in global coordinates and a degenerate flag. The
// core is a 78-stage pipeline that takes one query per clock unless a result is held by a stall;
// its depth is set mostly by the 32-step square root and the 33-step quotient pipelines.
// A stall on the result side freezes every stage at once, so nothing is dropped or repeated.
// The radii and length registers may only be written while no query is in flight.
module sphere_capsule_proximity_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  scp_pkg::query_t                  query,
	input  logic                             query_valid,
	output logic                             query_stall,
	output scp_pkg::result_t                 result,
	output logic                             result_valid,
	input  logic                             result_stall,
	input  logic                             wr_en,
	input  logic [scp_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [scp_pkg::RAD_W-1:0]        wr_data
);
	import scp_pkg::*;

	logic en;

	// configuration registers
	logic [RAD_W-1:0] sphere_radius_q;
	logic [RAD_W-1:0] cylinder_radius_q;
	logic [RAD_W-1:0] cylinder_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_radius_q   <= SPHERE_RADIUS_RST;
			cylinder_radius_q <= CYLINDER_RADIUS_RST;
			cylinder_length_q <= CYLINDER_LENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SPHERE_RADIUS:   sphere_radius_q   <= wr_data;
				REG_CYLINDER_RADIUS: cylinder_radius_q <= wr_data;
				REG_CYLINDER_LENGTH: cylinder_length_q <= wr_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances unless the output holds a stalled result
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	assign en          = !v_s13 || !result_stall;
	assign query_stall = !en;

	// stage 1: quaternion products and offset from the cylinder centre
	logic signed [QP_W-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [DV_W-1:0] dv_s1 [3];
	coord_t                 t_s1  [3];
	logic                   swap_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1    <= query.quat_i * query.quat_i;
			yy_s1    <= query.quat_j * query.quat_j;
			zz_s1    <= query.quat_k * query.quat_k;
			xy_s1    <= query.quat_i * query.quat_j;
			xz_s1    <= query.quat_i * query.quat_k;
			yz_s1    <= query.quat_j * query.quat_k;
			wx_s1    <= query.quat_w * query.quat_i;
			wy_s1    <= query.quat_w * query.quat_j;
			wz_s1    <= query.quat_w * query.quat_k;
			dv_s1[0] <= DV_W'(query.sphere_x) - DV_W'(query.cyl_x);
			dv_s1[1] <= DV_W'(query.sphere_y) - DV_W'(query.cyl_y);
			dv_s1[2] <= DV_W'(query.sphere_z) - DV_W'(query.cyl_z);
			t_s1[0]  <= query.cyl_x;
			t_s1[1]  <= query.cyl_y;
			t_s1[2]  <= query.cyl_z;
			swap_s1  <= query.swap_order;
		end
	end

	// stage 2: rotation matrix in q28
	rmat_t                  r_nx2;
	rmat_t                  r_s2;
	logic signed [DV_W-1:0] dv_s2 [3];
	coord_t                 t_s2  [3];
	logic                   swap_s2;

	always_comb begin
		coef_t cxx, cyy, czz, cxy, cxz, cyz, cwx, cwy, cwz;
		cxx = coef_t'(xx_s1); cyy = coef_t'(yy_s1); czz = coef_t'(zz_s1);
		cxy = coef_t'(xy_s1); cxz = coef_t'(xz_s1); cyz = coef_t'(yz_s1);
		cwx = coef_t'(wx_s1); cwy = coef_t'(wy_s1); cwz = coef_t'(wz_s1);
		r_nx2[0][0] = ONE_Q28 - ((cyy + czz) <<< 1);
		r_nx2[0][1] = (cxy - cwz) <<< 1;
		r_nx2[0][2] = (cxz + cwy) <<< 1;
		r_nx2[1][0] = (cxy + cwz) <<< 1;
		r_nx2[1][1] = ONE_Q28 - ((cxx + czz) <<< 1);
		r_nx2[1][2] = (cyz - cwx) <<< 1;
		r_nx2[2][0] = (cxz - cwy) <<< 1;
		r_nx2[2][1] = (cyz + cwx) <<< 1;
		r_nx2[2][2] = ONE_Q28 - ((cxx + cyy) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= r_nx2;
			dv_s2   <= dv_s1;
			t_s2    <= t_s1;
			swap_s2 <= swap_s1;
		end
	end

	// stage 3: transposed rotation products
	logic signed [PF_W-1:0] pf_s3 [3][3];
	rmat_t                  r_s3;
	coord_t                 t_s3 [3];
	logic                   swap_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pf_s3[i][j] <= $signed(r_s2[j][i]) * dv_s2[j];
				end
			end
			r_s3    <= r_s2;
			t_s3    <= t_s2;
			swap_s3 <= swap_s2;
		end
	end

	// stage 4: round and sum into the local frame
	loc_t   l_nx4 [3];
	loc_t   l_s4  [3];
	rmat_t  r_s4;
	coord_t t_s4 [3];
	logic   swap_s4;

	always_comb begin
		logic signed [RND_W-1:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++) begin
				acc = acc + rnd28(WIDE_W'(pf_s3[i][j]));
			end
			l_nx4[i] = acc[LOC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s4    <= l_nx4;
			r_s4    <= r_s3;
			t_s4    <= t_s3;
			swap_s4 <= swap_s3;
		end
	end

	// stage 5: axis point (radial or end cap) and offset magnitudes
	geo_t             geo_nx5;
	logic [MAG_W-1:0] um_nx5 [3];
	geo_t             geo_s5;
	logic [MAG_W-1:0] um_s5  [3];

	always_comb begin
		loc_t lm;
		loc_t h;
		loc_t a2;
		loc_t u [3];
		loc_t um;
		lm = l_s4[2][LOC_W-1] ? -l_s4[2] : l_s4[2];
		h  = {{(LOC_W-RAD_W+1){1'b0}}, cylinder_length_q[RAD_W-1:1]};
		if ({lm, 1'b0} <= {{(LOC_W+1-RAD_W){1'b0}}, cylinder_length_q}) begin
			a2 = l_s4[2];
		end else begin
			a2 = l_s4[2][LOC_W-1] ? -h : h;
		end
		u[0] = l_s4[0];
		u[1] = l_s4[1];
		u[2] = l_s4[2] - a2;
		for (int i = 0; i < 3; i++) begin
			um            = u[i][LOC_W-1] ? -u[i] : u[i];
			um_nx5[i]     = um[MAG_W-1:0];
			geo_nx5.neg[i] = u[i][LOC_W-1];
			geo_nx5.l[i]  = l_s4[i];
			geo_nx5.t[i]  = t_s4[i];
		end
		geo_nx5.a2   = a2;
		geo_nx5.r    = r_s4;
		geo_nx5.swap = swap_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5 <= geo_nx5;
			um_s5  <= um_nx5;
		end
	end

	// stage 6: common right shift so every component fits the squarer
	logic [SH_W-1:0]  sh_nx6;
	logic [SM_W-1:0]  sm_nx6 [3];
	logic [SH_W-1:0]  sh_s6;
	logic [SM_W-1:0]  sm_s6  [3];
	logic [MAG_W-1:0] um_s6  [3];
	geo_t             geo_s6;

	always_comb begin
		logic [MAG_W-1:0] mor;
		logic [MAG_W-1:0] tmp;
		mor    = um_s5[0] | um_s5[1] | um_s5[2];
		sh_nx6 = '0;
		for (int k = SM_W; k < MAG_W; k++) begin
			if (mor[k]) begin
				sh_nx6 = SH_W'(k - SM_W + 1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			tmp       = um_s5[i] >> sh_nx6;
			sm_nx6[i] = tmp[SM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s6  <= sh_nx6;
			sm_s6  <= sm_nx6;
			um_s6  <= um_s5;
			geo_s6 <= geo_s5;
		end
	end

	// stage 7: squares and split dividend products
	logic [SQ_W-1:0] sq_s7 [3];
	logic [PP_W-1:0] pl_s7 [LANES];
	logic [PP_W-1:0] ph_s7 [LANES];
	logic [SH_W-1:0] sh_s7;
	geo_t            geo_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= sm_s6[i] * sm_s6[i];
			end
			for (int k = 0; k < LANES; k++) begin
				pl_s7[k] <= um_s6[k % 3][RLO_W-1:0]
					* ((k < 3) ? sphere_radius_q : cylinder_radius_q);
				ph_s7[k] <= um_s6[k % 3][MAG_W-1:RLO_W]
					* ((k < 3) ? sphere_radius_q : cylinder_radius_q);
			end
			sh_s7  <= sh_s6;
			geo_s7 <= geo_s6;
		end
	end

	// stage 8: sum of squares and full dividends
	logic [SUM_W-1:0] sum_s8;
	sq_side_t         side_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
			for (int k = 0; k < LANES; k++) begin
				side_s8.num[k] <= (NUM_W'(ph_s7[k]) << RLO_W) + NUM_W'(pl_s7[k]);
			end
			side_s8.sh  <= sh_s7;
			side_s8.geo <= geo_s7;
		end
	end

	// square root pipeline
	logic                    sq_valid;
	logic [ROOT_W-1:0]       root;
	logic [$bits(sq_side_t)-1:0] sq_side_bits;
	sq_side_t                sq_side;

	scp_isqrt #(
		.N_W    (SUM_W),
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.arg_valid (v_s8),
		.arg       (sum_s8),
		.arg_side  (side_s8),
		.res_valid (sq_valid),
		.res       (root),
		.res_side  (sq_side_bits)
	);
	assign sq_side = sq_side_bits;

	// stage 9: norm, degenerate flag and distance
	logic [DEN_W-1:0]            d_nx9;
	coord_t                      dist_nx9;
	logic [DEN_W-1:0]            d_s9;
	logic [LANES-1:0][NUM_W-1:0] num_s9;
	div_side_t                   dside_s9;

	always_comb begin
		logic signed [RND_W-1:0] dd;
		d_nx9    = DEN_W'(root) << sq_side.sh;
		dd       = $signed({{(RND_W-DEN_W){1'b0}}, d_nx9})
			- $signed({{(RND_W-RAD_W){1'b0}}, sphere_radius_q})
			- $signed({{(RND_W-RAD_W){1'b0}}, cylinder_radius_q});
		dist_nx9 = sat_coord(dd);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s9         <= d_nx9;
			num_s9       <= sq_side.num;
			dside_s9.geo <= sq_side.geo;
			dside_s9.deg <= (root == '0);
			dside_s9.sep <= dist_nx9;
		end
	end

	// quotient pipeline: |u| * radius / d for both radii
	logic                        dq_valid;
	logic [LANES-1:0][QUO_W-1:0] quo;
	logic [$bits(div_side_t)-1:0] dq_side_bits;
	div_side_t                   dq_side;

	scp_div #(
		.LANES  (LANES),
		.NUM_W  (NUM_W),
		.DEN_W  (DEN_W),
		.QUO_W  (QUO_W),
		.SIDE_W ($bits(div_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.arg_valid (v_s9),
		.num       (num_s9),
		.den       (d_s9),
		.arg_side  (dside_s9),
		.res_valid (dq_valid),
		.quo       (quo),
		.res_side  (dq_side_bits)
	);
	assign dq_side = dq_side_bits;

	// stage 10: nearest points in the local frame
	logic signed [PT_W-1:0] ps_nx10 [3];
	logic signed [PT_W-1:0] pc_nx10 [3];
	logic signed [PT_W-1:0] ps_s10  [3];
	logic signed [PT_W-1:0] pc_s10  [3];
	rmat_t                  r_s10;
	coord_t                 t_s10 [3];
	logic                   swap_s10, deg_s10;
	coord_t                 dist_s10;

	always_comb begin
		logic signed [PT_W-1:0] qs;
		logic signed [PT_W-1:0] qc;
		logic signed [PT_W-1:0] ai;
		logic signed [PT_W-1:0] li;
		for (int i = 0; i < 3; i++) begin
			qs = $signed({{(PT_W-QUO_W){1'b0}}, quo[i]});
			qc = $signed({{(PT_W-QUO_W){1'b0}}, quo[i+3]});
			if (dq_side.geo.neg[i]) begin
				qs = -qs;
				qc = -qc;
			end
			ai = (i == 2) ? PT_W'($signed(dq_side.geo.a2)) : '0;
			li = PT_W'($signed(dq_side.geo.l[i]));
			if (dq_side.deg) begin
				ps_nx10[i] = ai;
				pc_nx10[i] = ai;
			end else begin
				ps_nx10[i] = li - qs;
				pc_nx10[i] = ai + qc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s10   <= ps_nx10;
			pc_s10   <= pc_nx10;
			r_s10    <= dq_side.geo.r;
			for (int i = 0; i < 3; i++) begin
				t_s10[i] <= dq_side.geo.t[i];
			end
			swap_s10 <= dq_side.geo.swap;
			deg_s10  <= dq_side.deg;
			dist_s10 <= dq_side.sep;
		end
	end

	// stage 11: rotate back, split partial products
	logic signed [MP_W-1:0] mh_s11 [2][3][3];
	logic signed [MP_W-1:0] ml_s11 [2][3][3];
	coord_t                 t_s11 [3];
	logic                   swap_s11, deg_s11;
	coord_t                 dist_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mh_s11[0][i][j] <= $signed(r_s10[i][j])
						* $signed(ps_s10[j][PT_W-1:SPLIT_LO]);
					ml_s11[0][i][j] <= $signed(r_s10[i][j])
						* $signed({1'b0, ps_s10[j][SPLIT_LO-1:0]});
					mh_s11[1][i][j] <= $signed(r_s10[i][j])
						* $signed(pc_s10[j][PT_W-1:SPLIT_LO]);
					ml_s11[1][i][j] <= $signed(r_s10[i][j])
						* $signed({1'b0, pc_s10[j][SPLIT_LO-1:0]});
				end
			end
			t_s11    <= t_s10;
			swap_s11 <= swap_s10;
			deg_s11  <= deg_s10;
			dist_s11 <= dist_s10;
		end
	end

	// stage 12: merge partial products and round
	logic signed [RND_W-1:0] g_nx12 [2][3][3];
	logic signed [RND_W-1:0] g_s12  [2][3][3];
	coord_t                  t_s12 [3];
	logic                    swap_s12, deg_s12;
	coord_t                  dist_s12;

	always_comb begin
		logic signed [WIDE_W-1:0] wide;
		for (int p = 0; p < 2; p++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					wide = (WIDE_W'(mh_s11[p][i][j]) <<< SPLIT_LO) + WIDE_W'(ml_s11[p][i][j]);
					g_nx12[p][i][j] = rnd28(wide);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s12    <= g_nx12;
			t_s12    <= t_s11;
			swap_s12 <= swap_s11;
			deg_s12  <= deg_s11;
			dist_s12 <= dist_s11;
		end
	end

	// stage 13: add the cylinder centre, saturate, order the points
	result_t res_nx13;
	result_t res_s13;

	always_comb begin
		logic signed [RND_W-1:0] acc;
		coord_t gp [2][3];
		for (int p = 0; p < 2; p++) begin
			for (int i = 0; i < 3; i++) begin
				acc = g_s12[p][i][0] + g_s12[p][i][1] + g_s12[p][i][2] + RND_W'(t_s12[i]);
				gp[p][i] = sat_coord(acc);
			end
		end
		res_nx13.distance   = dist_s12;
		res_nx13.first_x    = swap_s12 ? gp[1][0] : gp[0][0];
		res_nx13.first_y    = swap_s12 ? gp[1][1] : gp[0][1];
		res_nx13.first_z    = swap_s12 ? gp[1][2] : gp[0][2];
		res_nx13.second_x   = swap_s12 ? gp[0][0] : gp[1][0];
		res_nx13.second_y   = swap_s12 ? gp[0][1] : gp[1][1];
		res_nx13.second_z   = swap_s12 ? gp[0][2] : gp[1][2];
		res_nx13.degenerate = deg_s12;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s13 <= res_nx13;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= query_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= sq_valid;
			v_s10 <= dq_valid;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	assign result       = res_s13;
	assign result_valid = v_s13;

	// a degenerate result collapses both points onto the axis point
	a_deg_points: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.degenerate) |->
			(result.first_x == result.second_x && result.first_y == result.second_y
			&& result.first_z == result.second_z))
		else $error("degenerate result with distinct points");

	// each |u| is at most the norm plus the bits the shift drops, so a live quotient keeps its top bit clear
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dq_valid && !dq_side.deg) |->
			(quo[0][QUO_W-1] == 1'b0 && quo[1][QUO_W-1] == 1'b0 && quo[2][QUO_W-1] == 1'b0
			&& quo[3][QUO_W-1] == 1'b0 && quo[4][QUO_W-1] == 1'b0
			&& quo[5][QUO_W-1] == 1'b0))
		else $error("quotient out of range");

	// the divisor is nonzero exactly when the item is not degenerate
	a_deg_div: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> ((d_s9 == '0) == dside_s9.deg))
		else $error("degenerate flag disagrees with divisor");

endmodule

/* rtl/scp_isqrt.sv */
module scp_isqrt #(
	parameter int N_W    = 64,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              arg_valid,
	input  logic [N_W-1:0]    arg,
	input  logic [SIDE_W-1:0] arg_side,
	output logic              res_valid,
	output logic [N_W/2-1:0]  res,
	output logic [SIDE_W-1:0] res_side
);

	localparam int R_W   = N_W / 2;
	localparam int REM_W = R_W + 3;
	localparam int STEPS = R_W;

	logic [REM_W-1:0]  rem_s  [STEPS];
	logic [R_W-1:0]    root_s [STEPS];
	logic [N_W-1:0]    rest_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic [STEPS-1:0]  valid_s;

	// one root bit per stage, two radicand bits shifted in each time
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [REM_W-1:0]  rem_in;
		logic [R_W-1:0]    root_in;
		logic [N_W-1:0]    rest_in;
		logic [SIDE_W-1:0] side_in;
		logic              valid_in;
		logic [REM_W-1:0]  rem2;
		logic [REM_W-1:0]  trial;
		logic [REM_W-1:0]  rem_nx;
		logic [R_W-1:0]    root_nx;

		if (k == 0) begin : g_first
			assign rem_in   = '0;
			assign root_in  = '0;
			assign rest_in  = arg;
			assign side_in  = arg_side;
			assign valid_in = arg_valid;
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign root_in  = root_s[k-1];
			assign rest_in  = rest_s[k-1];
			assign side_in  = side_s[k-1];
			assign valid_in = valid_s[k-1];
		end

		always_comb begin
			rem2  = {rem_in[REM_W-3:0], rest_in[N_W-1 -: 2]};
			trial = {1'b0, root_in, 2'b01};
			if (rem2 >= trial) begin
				rem_nx  = rem2 - trial;
				root_nx = {root_in[R_W-2:0], 1'b1};
			end else begin
				rem_nx  = rem2;
				root_nx = {root_in[R_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				root_s[k] <= root_nx;
				rest_s[k] <= rest_in << 2;
				side_s[k] <= side_in;
			end
		end
	end

	assign res_valid = valid_s[STEPS-1];
	assign res       = root_s[STEPS-1];
	assign res_side  = side_s[STEPS-1];

endmodule

/* rtl/scp_div.sv */
module scp_div #(
	parameter int LANES  = 6,
	parameter int NUM_W  = 69,
	parameter int DEN_W  = 40,
	parameter int QUO_W  = 33,
	parameter int SIDE_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        arg_valid,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  logic [DEN_W-1:0]            den,
	input  logic [SIDE_W-1:0]           arg_side,
	output logic                        res_valid,
	output logic [LANES-1:0][QUO_W-1:0] quo,
	output logic [SIDE_W-1:0]           res_side
);

	localparam int STEPS = QUO_W;
	localparam int REM_W = DEN_W + 1;

	logic [REM_W-1:0]  rem_s  [STEPS][LANES];
	logic [QUO_W-1:0]  lo_s   [STEPS][LANES];
	logic [DEN_W-1:0]  den_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic [STEPS-1:0]  valid_s;

	// restoring division, one quotient bit per stage and lane, shared divisor
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [REM_W-1:0]  rem_in [LANES];
		logic [QUO_W-1:0]  lo_in  [LANES];
		logic [DEN_W-1:0]  den_in;
		logic [SIDE_W-1:0] side_in;
		logic              valid_in;
		logic [REM_W-1:0]  rem_nx [LANES];
		logic [QUO_W-1:0]  lo_nx  [LANES];

		if (k == 0) begin : g_first
			for (genvar n = 0; n < LANES; n++) begin : g_lane
				assign rem_in[n] = {{(REM_W-NUM_W+QUO_W){1'b0}}, num[n][NUM_W-1:QUO_W]};
				assign lo_in[n]  = num[n][QUO_W-1:0];
			end
			assign den_in   = den;
			assign side_in  = arg_side;
			assign valid_in = arg_valid;
		end else begin : g_next
			for (genvar n = 0; n < LANES; n++) begin : g_lane
				assign rem_in[n] = rem_s[k-1][n];
				assign lo_in[n]  = lo_s[k-1][n];
			end
			assign den_in   = den_s[k-1];
			assign side_in  = side_s[k-1];
			assign valid_in = valid_s[k-1];
		end

		always_comb begin
			logic [REM_W-1:0] rem2;
			for (int n = 0; n < LANES; n++) begin
				rem2 = {rem_in[n][DEN_W-1:0], lo_in[n][QUO_W-1]};
				if (rem2 >= {1'b0, den_in}) begin
					rem_nx[n] = rem2 - {1'b0, den_in};
					lo_nx[n]  = {lo_in[n][QUO_W-2:0], 1'b1};
				end else begin
					rem_nx[n] = rem2;
					lo_nx[n]  = {lo_in[n][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int n = 0; n < LANES; n++) begin
					rem_s[k][n] <= rem_nx[n];
					lo_s[k][n]  <= lo_nx[n];
				end
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	for (genvar n = 0; n < LANES; n++) begin : g_out
		assign quo[n] = lo_s[STEPS-1][n];
	end
	assign res_valid = valid_s[STEPS-1];
	assign res_side  = side_s[STEPS-1];

endmodule

/* tb/sphere_capsule_proximity_core_tb.sv */
`timescale 1ns / 100ps

module sphere_capsule_proximity_core_tb;
	import scp_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PIPE_DEPTH  = 78;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;
	localparam longint LOCAL_CAP = 64'sd1 << 50;
	localparam longint MAG_CAP   = 64'sd1 << 62;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam longint unsigned SQ_LIM = 64'd1 << 31;

	// expected results of the sphere to capsule distance query
	class proximity_scoreboard;
		longint unsigned sph_rad, cyl_rad, cyl_len;
		result_t expected_results[$];
		int mismatches;
		int checked;

		function void reset_regs();
			sph_rad = SPHERE_RADIUS_RST;
			cyl_rad = CYLINDER_RADIUS_RST;
			cyl_len = CYLINDER_LENGTH_RST;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
			case (idx)
				REG_SPHERE_RADIUS: sph_rad = val;
				REG_CYLINDER_RADIUS: cyl_rad = val;
				REG_CYLINDER_LENGTH: cyl_len = val;
				default: ;
			endcase
		endfunction

		function longint unsigned magn(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// (a*b) >> 28 rounded half away from zero, magnitude capped
		function longint q28_mul(longint a, longint b);
			logic [127:0] pr;
			longint unsigned r;
			pr = {64'd0, magn(a)} * {64'd0, magn(b)} + (128'd1 << 27);
			pr = pr >> 28;
			r = (pr > 128'(MAG_CAP)) ? MAG_CAP : pr[63:0];
			return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
		endfunction

		// v*r/d with truncated magnitude, sign of v
		function longint scale_by(longint v, longint unsigned r, longint unsigned d);
			logic [127:0] pr;
			logic [127:0] q;
			pr = {64'd0, magn(v)} * {64'd0, r};
			if (pr[127:64] >= d) q = MAG_CAP;
			else q = pr / {64'd0, d};
			if (q > 128'(MAG_CAP)) q = MAG_CAP;
			return v < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint unsigned vec_length(longint c[3]);
			longint unsigned m[3];
			longint unsigned sum;
			int s;
			sum = 0;
			s = 0;
			foreach (m[i]) m[i] = magn(c[i]);
			while ((m[0] >> s) >= SQ_LIM || (m[1] >> s) >= SQ_LIM || (m[2] >> s) >= SQ_LIM) s++;
			foreach (m[i]) sum += (m[i] >> s) * (m[i] >> s);
			return int_sqrt(sum) << s;
		endfunction

		function result_t predict(query_t q);
			longint w, x, y, z, h, sep;
			longint rm[3][3];
			longint t[3], dv[3], lc[3], ax[3], u[3], ps[3], pc[3], gs[3], gc[3];
			longint acc, as_s, as_c;
			longint unsigned d;
			logic deg;
			result_t r;
			w = q.quat_w; x = q.quat_i; y = q.quat_j; z = q.quat_k;
			rm[0][0] = (64'sd1 << 28) - 2 * (y * y + z * z);
			rm[0][1] = 2 * (x * y - w * z);
			rm[0][2] = 2 * (x * z + w * y);
			rm[1][0] = 2 * (x * y + w * z);
			rm[1][1] = (64'sd1 << 28) - 2 * (x * x + z * z);
			rm[1][2] = 2 * (y * z - w * x);
			rm[2][0] = 2 * (x * z - w * y);
			rm[2][1] = 2 * (y * z + w * x);
			rm[2][2] = (64'sd1 << 28) - 2 * (x * x + y * y);
			t[0] = q.cyl_x; t[1] = q.cyl_y; t[2] = q.cyl_z;
			dv[0] = longint'(q.sphere_x) - t[0];
			dv[1] = longint'(q.sphere_y) - t[1];
			dv[2] = longint'(q.sphere_z) - t[2];
			// into the cylinder frame with the transposed rotation
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) acc += q28_mul(rm[j][i], dv[j]);
				lc[i] = clip(acc, -LOCAL_CAP, LOCAL_CAP);
			end
			// radial projection inside the length, else nearer end centre
			h = cyl_len >> 1;
			ax[0] = 0;
			ax[1] = 0;
			if (2 * magn(lc[2]) <= cyl_len) ax[2] = lc[2];
			else ax[2] = lc[2] < 0 ? -h : h;
			foreach (u[i]) u[i] = lc[i] - ax[i];
			d = vec_length(u);
			deg = (d == 0);
			for (int i = 0; i < 3; i++) begin
				if (deg) begin
					ps[i] = ax[i];
					pc[i] = ax[i];
				end else begin
					ps[i] = lc[i] - scale_by(u[i], sph_rad, d);
					pc[i] = ax[i] + scale_by(u[i], cyl_rad, d);
				end
			end
			// back to global coordinates
			for (int i = 0; i < 3; i++) begin
				as_s = 0;
				as_c = 0;
				for (int j = 0; j < 3; j++) begin
					as_s += q28_mul(rm[i][j], ps[j]);
					as_c += q28_mul(rm[i][j], pc[j]);
				end
				gs[i] = clip(as_s + t[i], COORD_MIN, COORD_MAX);
				gc[i] = clip(as_c + t[i], COORD_MIN, COORD_MAX);
			end
			sep = clip(longint'(d) - longint'(sph_rad) - longint'(cyl_rad), COORD_MIN, COORD_MAX);
			r.distance = sep[31:0];
			r.first_x  = q.swap_order ? gc[0][31:0] : gs[0][31:0];
			r.first_y  = q.swap_order ? gc[1][31:0] : gs[1][31:0];
			r.first_z  = q.swap_order ? gc[2][31:0] : gs[2][31:0];
			r.second_x = q.swap_order ? gs[0][31:0] : gc[0][31:0];
			r.second_y = q.swap_order ? gs[1][31:0] : gc[1][31:0];
			r.second_z = q.swap_order ? gs[2][31:0] : gc[2][31:0];
			r.degenerate = deg;
			return r;
		endfunction

		function void note_query(query_t q);
			expected_results.push_back(predict(q));
		endfunction

		function void fail_msg(string what, logic [31:0] e, logic [31:0] a);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h got %h (result %0d)", what, e, a, checked);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction: %p", got);
				return;
			end
			e = expected_results.pop_front();
			if (got.distance !== e.distance) fail_msg("distance", e.distance, got.distance);
			if (got.first_x !== e.first_x) fail_msg("first_x", e.first_x, got.first_x);
			if (got.first_y !== e.first_y) fail_msg("first_y", e.first_y, got.first_y);
			if (got.first_z !== e.first_z) fail_msg("first_z", e.first_z, got.first_z);
			if (got.second_x !== e.second_x) fail_msg("second_x", e.second_x, got.second_x);
			if (got.second_y !== e.second_y) fail_msg("second_y", e.second_y, got.second_y);
			if (got.second_z !== e.second_z) fail_msg("second_z", e.second_z, got.second_z);
			if (got.degenerate !== e.degenerate)
				fail_msg("degenerate", 32'(e.degenerate), 32'(got.degenerate));
			checked++;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	query_t query;
	logic query_valid;
	logic query_stall;
	result_t result;
	logic result_valid;
	logic result_stall;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [RAD_W-1:0] wr_data;

	proximity_scoreboard sb;
	int cycles;
	bit hold_req;
	int hold_left;
	int seg_left;
	int stall_pct;
	int sent;
	int n_deg;

	sphere_capsule_proximity_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: check accepted transactions, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (result.degenerate) n_deg++;
			sb.check_result(result);
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			result_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(5, 60);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 70;
				endcase
			end
			seg_left--;
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_query(query_t q);
		query <= q;
		query_valid <= 1'b1;
		do @(posedge clk); while (query_stall);
		sb.note_query(q);
		sent++;
	endtask

	task automatic idle_cycles(int n);
		query_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		query_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		wr_en <= 1'b0;
	endtask

	task automatic set_shape(logic [RAD_W-1:0] sr, logic [RAD_W-1:0] cr, logic [RAD_W-1:0] cl);
		write_reg(REG_SPHERE_RADIUS, sr);
		write_reg(REG_CYLINDER_RADIUS, cr);
		write_reg(REG_CYLINDER_LENGTH, cl);
	endtask

	function automatic query_t make_query(coord_t sx, coord_t sy, coord_t sz, coord_t cx,
			coord_t cy, coord_t cz, quat_t qw, quat_t qi, quat_t qj, quat_t qk, logic sw);
		query_t q;
		q.sphere_x = sx; q.sphere_y = sy; q.sphere_z = sz;
		q.cyl_x = cx; q.cyl_y = cy; q.cyl_z = cz;
		q.quat_w = qw; q.quat_i = qi; q.quat_j = qj; q.quat_k = qk;
		q.swap_order = sw;
		return q;
	endfunction

	function automatic coord_t rand_coord(int span);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $signed($urandom_range(0, 2 ** span)) - (2 ** (span - 1));
	endfunction

	// query with a unit quaternion most of the time, raw bits otherwise
	function automatic query_t rand_query();
		query_t q;
		real a[4];
		real n;
		int span;
		span = $urandom_range(12, 24);
		q.sphere_x = rand_coord(span); q.sphere_y = rand_coord(span);
		q.sphere_z = rand_coord(span);
		q.cyl_x = rand_coord(span); q.cyl_y = rand_coord(span); q.cyl_z = rand_coord(span);
		q.swap_order = $urandom_range(0, 1);
		if ($urandom_range(0, 7) == 0) begin
			{q.quat_w, q.quat_i} = $urandom;
			{q.quat_j, q.quat_k} = $urandom;
		end else begin
			n = 0.0;
			foreach (a[i]) begin
				a[i] = $itor($signed($urandom_range(0, 2000)) - 1000);
				n += a[i] * a[i];
			end
			if (n == 0.0) begin
				a[0] = 1.0;
				n = 1.0;
			end
			n = $sqrt(n);
			q.quat_w = $rtoi(a[0] / n * 16383.0);
			q.quat_i = $rtoi(a[1] / n * 16383.0);
			q.quat_j = $rtoi(a[2] / n * 16383.0);
			q.quat_k = $rtoi(a[3] / n * 16383.0);
		end
		return q;
	endfunction

	task automatic random_burst(int count);
		int k;
		int burst;
		k = 0;
		while (k < count) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && k < count; b++) begin
				send_query(rand_query());
				k++;
			end
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		clk = 1'b0;
		arst_n = 1'b0;
		query = '0;
		query_valid = 1'b0;
		result_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_SPHERE_RADIUS;
		wr_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset shape, axis cases, ends, extremes
		send_query(make_query(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_query(make_query(0, 0, 32'sh8000, 0, 0, 0, 16384, 0, 0, 0, 1));
		send_query(make_query(32'sh30000, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_query(make_query(32'sh30000, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 1));
		send_query(make_query(0, 0, 32'sh50000, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_query(make_query(0, 0, -32'sh50000, 0, 0, 0, 16384, 0, 0, 0, 1));
		send_query(make_query(0, 0, 32'sh10000, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_query(make_query(32'sh10000, 32'sh20000, 32'sh30000, 32'sh1000, -32'sh2000, 0,
			11585, 11585, 0, 0, 0));
		send_query(make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 16384, 0, 0, 0, 0));
		send_query(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16384, 0, 0, 0, 1));
		send_query(make_query(32'sh7fffffff, 0, 32'sh80000000, 0, 32'sh7fffffff, 0,
			-32768, -32768, -32768, -32768, 0));
		send_query(make_query(32'sh12345, -32'sh54321, 32'sh777, 0, 0, 0,
			32767, 32767, 32767, 32767, 1));
		send_query(make_query(32'sh40000, 32'sh40000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(32'sh40000, -32'sh40000, 32'sh100000, 0, 0, 0, 0, 16384, 0, 0, 1));
		send_query(make_query(32'sh5000, 32'sh6000, 32'sh7000, 32'sh5000, 32'sh6000, 32'sh7000,
			0, 0, 0, 16384, 0));
		drain();

		// zero radii and zero length, with an ignored index
		set_shape(0, 0, 0);
		write_reg(REG_UNUSED, 31'h7fffffff);
		send_query(make_query(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_query(make_query(0, 0, 32'sh1, 0, 0, 0, 16384, 0, 0, 0, 1));
		send_query(make_query(32'sh3000, 0, -32'sh9000, 0, 0, 0, 16384, 0, 0, 0, 0));
		random_burst(60);
		drain();

		// largest radii and length
		set_shape(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		send_query(make_query(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 16384, 0, 0, 0, 0));
		send_query(make_query(0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 16384, 0, 0, 0, 1));
		random_burst(60);
		drain();

		// back to small fixed shapes, receiver holds off while the sender keeps pushing
		set_shape(31'h10000, 31'h8000, 31'h40000);
		hold_req = 1'b1;
		for (int i = 0; i < 150; i++) send_query(rand_query());
		drain();

		// several random shapes, with a pause that lets the pipe empty
		for (int ph = 0; ph < 3; ph++) begin
			set_shape($urandom_range(0, 31'h80000), $urandom_range(0, 31'h80000),
				$urandom_range(0, 31'h200000));
			random_burst(30);
			drain();
			random_burst(20);
			drain();
		end

		$display("%0d queries over several shape settings, %0d results checked, %0d degenerate",
			sent, sb.checked, n_deg);
		$display("covered long output hold-off, full-range and zero-size shapes");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
